[rtl/u8d_pkg.sv]
// u8d_pkg: shared types and constants for the utf-8 stream decoder
// status codes, decoder state and result structs, lead byte thresholds
// no dependencies
package u8d_pkg;

    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_MORE     = 2'd1,
        ST_ILLEGAL  = 2'd2,
        ST_END      = 2'd3
    } t_status;

    localparam int CpWidth  = 31;
    localparam int LenWidth = 3;

    // lead byte lower bounds, highest length first
    localparam logic [7:0] LeadBad  = 8'hFE;
    localparam logic [7:0] Lead6    = 8'hFC;
    localparam logic [7:0] Lead5    = 8'hF8;
    localparam logic [7:0] Lead4    = 8'hF0;
    localparam logic [7:0] Lead3    = 8'hE0;
    localparam logic [7:0] Lead2    = 8'hC0;
    localparam logic [7:0] ContBase = 8'h80;

    localparam logic [1:0] ContTag = 2'b10;

    typedef struct packed {
        logic [LenWidth-1:0] remaining;
        logic [CpWidth-1:0]  acc;
        logic [LenWidth-1:0] total;
    } t_dec_state;

    typedef struct packed {
        logic [CpWidth-1:0]  code_point;
        logic [LenWidth-1:0] seq_length;
        t_status             status;
    } t_dec_result;

endpackage

[rtl/utf8_stream_decoder.sv]
// a beat moves from the input register into the result register
// throughput: one byte per cycle; the input register, the decode logic and
// the result register advance together whenever the result register is free
// reset (synchronous, active low): pipeline empty, decoder idle with
// no sequence in progress and a cleared accumulator
module utf8_stream_decoder #(
    parameter int MAX_SEQ_BYTES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_flush,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_code_point,
    output logic [2:0]  o_seq_length,
    output logic [1:0]  o_status
);

    logic                  r_in_valid;
    logic [7:0]            r_byte;
    logic                  r_flush;
    u8d_pkg::t_dec_state   r_state;
    u8d_pkg::t_dec_state   n_state;
    u8d_pkg::t_dec_result  n_result;
    u8d_pkg::t_dec_result  r_result;
    logic                  r_out_valid;
    logic                  out_free;
    logic                  advance;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    u8d_step #(
        .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
    ) u_step (
        .i_data_byte(r_byte),
        .i_flush    (r_flush),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{remaining: '0, acc: '0, total: '0};
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte  <= i_data_byte;
            r_flush <= i_flush;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_result.code_point;
    assign o_seq_length = r_result.seq_length;
    assign o_status     = r_result.status;

endmodule

[rtl/u8d_step.sv]
// u8d_step: combinational next-state and result logic for one beat
// lead decode, continuation check and six-bit accumulate
// depends on u8d_pkg
module u8d_step #(
    parameter int MAX_SEQ_BYTES = 6
) (
    input  logic [7:0]          i_data_byte,
    input  logic                i_flush,
    input  u8d_pkg::t_dec_state i_state,
    output u8d_pkg::t_dec_state o_state,
    output u8d_pkg::t_dec_result o_result
);

    localparam logic [2:0] MaxLen = 3'(MAX_SEQ_BYTES);

    logic [2:0]                   lead_len;
    logic [6:0]                   lead_payload;
    logic [u8d_pkg::CpWidth-1:0]  acc_shift;
    u8d_pkg::t_dec_state          idle_state;

    assign idle_state = '{remaining: '0, acc: '0, total: '0};
    assign acc_shift  = {i_state.acc[u8d_pkg::CpWidth-7:0], i_data_byte[5:0]};

    always_comb begin
        lead_len     = 3'd0;
        lead_payload = 7'd0;
        if (i_data_byte >= u8d_pkg::LeadBad) begin
            lead_len = 3'd0;
        end else if (i_data_byte >= u8d_pkg::Lead6) begin
            lead_len     = 3'd6;
            lead_payload = {6'd0, i_data_byte[0]};
        end else if (i_data_byte >= u8d_pkg::Lead5) begin
            lead_len     = 3'd5;
            lead_payload = {5'd0, i_data_byte[1:0]};
        end else if (i_data_byte >= u8d_pkg::Lead4) begin
            lead_len     = 3'd4;
            lead_payload = {4'd0, i_data_byte[2:0]};
        end else if (i_data_byte >= u8d_pkg::Lead3) begin
            lead_len     = 3'd3;
            lead_payload = {3'd0, i_data_byte[3:0]};
        end else if (i_data_byte >= u8d_pkg::Lead2) begin
            lead_len     = 3'd2;
            lead_payload = {2'd0, i_data_byte[4:0]};
        end else if (i_data_byte < u8d_pkg::ContBase) begin
            lead_len     = 3'd1;
            lead_payload = i_data_byte[6:0];
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '{code_point: '0, seq_length: '0, status: u8d_pkg::ST_MORE};
        if (i_flush) begin
            o_state = idle_state;
            if (i_state.remaining != 3'd0) begin
                o_result.status = u8d_pkg::ST_ILLEGAL;
            end else begin
                o_result.status = u8d_pkg::ST_END;
            end
        end else if (i_state.remaining == 3'd0) begin
            if (lead_len == 3'd0 || lead_len > MaxLen) begin
                o_state         = idle_state;
                o_result.status = u8d_pkg::ST_ILLEGAL;
            end else if (lead_len == 3'd1) begin
                o_state             = idle_state;
                o_result.code_point = {24'd0, lead_payload};
                o_result.seq_length = 3'd1;
                o_result.status     = u8d_pkg::ST_COMPLETE;
            end else begin
                o_state.remaining = lead_len - 3'd1;
                o_state.acc       = {24'd0, lead_payload};
                o_state.total     = lead_len;
            end
        end else if (i_data_byte[7:6] != u8d_pkg::ContTag) begin
            // bad continuation is consumed, never re-read as a lead
            o_state         = idle_state;
            o_result.status = u8d_pkg::ST_ILLEGAL;
        end else if (i_state.remaining == 3'd1) begin
            o_state             = idle_state;
            o_result.code_point = acc_shift;
            o_result.seq_length = i_state.total;
            o_result.status     = u8d_pkg::ST_COMPLETE;
        end else begin
            o_state.remaining = i_state.remaining - 3'd1;
            o_state.acc       = acc_shift;
        end
    end

endmodule

[rtl/u8d_checker.sv]
// u8d_checker: port-level assertions for utf8_stream_decoder
// bound to the top level below; depends on u8d_pkg
module u8d_checker #(
    parameter int MAX_SEQ_BYTES = 6
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [30:0] o_code_point,
    input logic [2:0]  o_seq_length,
    input logic [1:0]  o_status
);

    localparam logic [2:0] MaxLen = 3'(MAX_SEQ_BYTES);

    // only a completed beat carries a length or a code point
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != u8d_pkg::ST_COMPLETE |->
            o_seq_length == 3'd0 && o_code_point == 31'd0)
        else $error("non-complete result carries data");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == u8d_pkg::ST_COMPLETE |->
            o_seq_length != 3'd0 && o_seq_length <= MaxLen)
        else $error("complete result with bad length");

    // single byte sequences hold seven bits at most
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == u8d_pkg::ST_COMPLETE && o_seq_length == 3'd1 |->
            o_code_point[30:7] == 24'd0)
        else $error("single byte code point too wide");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_point) &&
            $stable(o_seq_length) && $stable(o_status))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind utf8_stream_decoder u8d_checker #(
    .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
) u_checker (.*);

[test/u8d_tb_pkg.sv]
// u8d_tb_pkg: character scoreboard for the utf-8 stream decoder bench
// keeps its own copy of the decode state and a queue of expected result beats
// depends on u8d_pkg for the status codes, result struct and lead byte bounds
package u8d_tb_pkg;

    import u8d_pkg::*;

    localparam int MaxSeqBytes = 6;

    class u8d_char_board;

        logic [2:0]  cont_left;
        logic [30:0] cp_acc;
        logic [2:0]  char_len;
        t_dec_result pending_chars[$];
        int          mismatches;

        function new();
            drop_sequence();
            mismatches = 0;
        endfunction

        function void drop_sequence();
            cont_left = '0;
            cp_acc    = '0;
            char_len  = '0;
        endfunction

        // advance the decode state by one beat and return the result it gives
        function t_dec_result decode_beat(logic [7:0] b, logic flush);
            t_dec_result r;
            int          lead_len;
            logic [30:0] lead_bits;
            r.code_point = '0;
            r.seq_length = '0;
            r.status     = ST_ILLEGAL;
            lead_len     = 0;
            lead_bits    = '0;
            if (flush) begin
                r.status = (cont_left != 0) ? ST_ILLEGAL : ST_END;
                drop_sequence();
            end else if (cont_left == 0) begin
                if (b >= LeadBad) begin
                    lead_len = 0;
                end else if (b >= Lead6) begin
                    lead_len = 6;
                    lead_bits = 31'(b[0]);
                end else if (b >= Lead5) begin
                    lead_len = 5;
                    lead_bits = 31'(b[1:0]);
                end else if (b >= Lead4) begin
                    lead_len = 4;
                    lead_bits = 31'(b[2:0]);
                end else if (b >= Lead3) begin
                    lead_len = 3;
                    lead_bits = 31'(b[3:0]);
                end else if (b >= Lead2) begin
                    lead_len = 2;
                    lead_bits = 31'(b[4:0]);
                end else if (b < ContBase) begin
                    lead_len = 1;
                    lead_bits = 31'(b[6:0]);
                end
                if (lead_len == 0 || lead_len > MaxSeqBytes) begin
                    drop_sequence();
                end else if (lead_len == 1) begin
                    r.code_point = lead_bits;
                    r.seq_length = 3'd1;
                    r.status     = ST_COMPLETE;
                    drop_sequence();
                end else begin
                    cont_left = 3'(lead_len - 1);
                    cp_acc    = lead_bits;
                    char_len  = 3'(lead_len);
                    r.status  = ST_MORE;
                end
            end else if (b[7:6] != ContTag) begin
                // bad continuation is swallowed, not retried as a lead
                drop_sequence();
            end else begin
                cp_acc    = {cp_acc[24:0], b[5:0]};
                cont_left = cont_left - 3'd1;
                if (cont_left == 0) begin
                    r.code_point = cp_acc;
                    r.seq_length = char_len;
                    r.status     = ST_COMPLETE;
                    drop_sequence();
                end else begin
                    r.status = ST_MORE;
                end
            end
            return r;
        endfunction

        function void note_byte(logic [7:0] b, logic flush);
            pending_chars.push_back(decode_beat(b, flush));
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_char(logic [30:0] cp, logic [2:0] len, logic [1:0] st);
            t_dec_result want;
            if (pending_chars.size() == 0) begin
                report($sformatf("result beat with nothing pending cp=%h len=%0d st=%0d",
                                 cp, len, st));
            end else begin
                want = pending_chars.pop_front();
                if (cp !== want.code_point)
                    report($sformatf("code_point %h, want %h", cp, want.code_point));
                if (len !== want.seq_length)
                    report($sformatf("seq_length %0d, want %0d", len, want.seq_length));
                if (st !== 2'(want.status))
                    report($sformatf("status %0d, want %0d", st, want.status));
            end
        endtask

    endclass

endpackage

[test/utf8_stream_decoder_tb.sv]
// utf8_stream_decoder_tb: top of the utf-8 stream decoder bench
// directed byte sequences then random good and bad traffic under idle and stall phases
// depends on u8d_pkg, u8d_tb_pkg and the utf8_stream_decoder rtl
module utf8_stream_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;
    import u8d_tb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_flush;
    logic        o_valid;
    logic        i_stall;
    logic [30:0] o_code_point;
    logic [2:0]  o_seq_length;
    logic [1:0]  o_status;

    u8d_char_board board;
    int            idle_pct;
    int            stall_pct;
    bit            draining;

    utf8_stream_decoder #(
        .MAX_SEQ_BYTES(MaxSeqBytes)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_flush     (i_flush),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code_point(o_code_point),
        .o_seq_length(o_seq_length),
        .o_status    (o_status)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= !draining && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_valid && !o_stall)
            board.note_byte(i_data_byte, i_flush);
        if (o_valid && !i_stall)
            board.check_char(o_code_point, o_seq_length, o_status);
    end

    // valid stays high across back-to-back beats, only the payload moves
    task send_beat(logic [7:0] b, logic flush);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_flush     <= flush;
        do @(posedge i_clk); while (o_stall);
    endtask

    task send_byte(logic [7:0] b);
        send_beat(b, 1'b0);
    endtask

    task send_flush();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    task wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending_chars.size() != 0)
            @(posedge i_clk);
    endtask

    // a len byte sequence, random payload; cut_short ends it early via flush or bad byte
    task send_char(int len, bit cut_short);
        logic [7:0] b;
        int         conts;
        b = 8'($urandom_range(255));
        case (len)
            1: b[7]   = 1'b0;
            2: b[7:5] = 3'b110;
            3: b[7:4] = 4'b1110;
            4: b[7:3] = 5'b11110;
            5: b[7:2] = 6'b111110;
            default: b[7:1] = 7'b1111110;
        endcase
        send_byte(b);
        conts = cut_short ? $urandom_range(len - 2, 0) : len - 1;
        repeat (conts) send_byte({2'b10, 6'($urandom_range(63))});
        if (cut_short) begin
            if ($urandom_range(1)) begin
                send_flush();
            end else begin
                do b = 8'($urandom_range(255)); while (b[7:6] == ContTag);
                send_byte(b);
            end
        end
    endtask

    task run_traffic(int n_beats);
        int  sent;
        int  pick;
        sent = 0;
        while (sent < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                pick = $urandom_range(6, 1);
                send_char(pick, 1'b0);
                sent += pick;
            end else if (pick < 82) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else if (pick < 90) begin
                send_flush();
                sent++;
            end else begin
                pick = $urandom_range(6, 2);
                send_char(pick, 1'b1);
                sent += pick;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_flush     = 1'b0;
        i_stall     = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        draining    = 1'b0;
        board       = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single byte extremes
        send_byte(8'h00);
        send_byte(8'h7F);
        // two, three, five and six byte characters, six byte at full scale
        send_byte(8'hC2); send_byte(8'hA9);
        send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
        send_byte(8'hF8); send_byte(8'h88); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'hFD);
        repeat (5) send_byte(8'hBF);
        // stray continuation, never-valid leads
        send_byte(8'h80);
        send_byte(8'hFE);
        send_byte(8'hFF);
        // bad continuation swallowed
        send_byte(8'hE2); send_byte(8'h41);
        // flush idle, then flush cutting a sequence
        send_beat(8'hFF, 1'b1);
        send_byte(8'hC3); send_beat(8'h00, 1'b1);
        wait_drained();

        run_traffic(280);
        wait_drained();

        idle_pct = 87;
        run_traffic(280);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 87;
        run_traffic(280);
        wait_drained();

        idle_pct  = 24;
        stall_pct = 24;
        run_traffic(280);
        wait_drained();

        draining = 1'b1;
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/u8d_pkg.sv
rtl/u8d_step.sv
rtl/utf8_stream_decoder.sv
rtl/u8d_checker.sv
test/u8d_tb_pkg.sv
test/utf8_stream_decoder_tb.sv
